/* src/rdmt_pkg.sv */
package rdmt_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int SPEED_W = 16;
  localparam int ROW_W   = 48;
  localparam int STRIDE  = 16;
  localparam int CFRAC   = COEF_W - 2;
  localparam int RSHIFT  = 2 * CFRAC - 1;

  // derived datapath widths
  localparam int MPROD_W = COEF_W + COORD_W;     // mount product
  localparam int MSUM_W  = MPROD_W + 2;          // sum of three
  localparam int QPROD_W = 2 * COEF_W;           // quaternion product
  localparam int RCOEF_W = QPROD_W + 2;          // vehicle matrix entry
  localparam int RPROD_W = RCOEF_W + COORD_W;    // rotation product
  localparam int RSUM_W  = RPROD_W + 2;
  localparam int SATIN_W = RSUM_W - RSHIFT + 1;  // pre-saturation coordinate

  // commands
  localparam logic [1:0] CMD_DET  = 2'd0;
  localparam logic [1:0] CMD_POSE = 2'd1;
  localparam logic [1:0] CMD_VEL  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ROW0 = 3'd0;
  localparam logic [2:0] REG_ROW1 = 3'd1;
  localparam logic [2:0] REG_ROW2 = 3'd2;
  localparam logic [2:0] REG_OFSX = 3'd3;
  localparam logic [2:0] REG_OFSY = 3'd4;
  localparam logic [2:0] REG_OFSZ = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [RCOEF_W-1:0] rcoef_t;

  // stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  function automatic coord_t sat_coord(input logic signed [SATIN_W-1:0] v);
    logic signed [SATIN_W-1:0] hi;
    logic signed [SATIN_W-1:0] lo;
    hi = SATIN_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - SATIN_W'(1);
    if (v > hi) sat_coord = coord_t'(hi);
    else if (v < lo) sat_coord = coord_t'(lo);
    else sat_coord = v[COORD_W-1:0];
  endfunction

  function automatic speed_t sat_speed(input logic signed [SPEED_W:0] v);
    if (v[SPEED_W] != v[SPEED_W-1])
      sat_speed = v[SPEED_W] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
    else
      sat_speed = v[SPEED_W-1:0];
  endfunction

endpackage

/* src/rdmt_mount.sv */
module rdmt_mount (
  input  logic                        clk,
  input  rdmt_pkg::stage_en_t         en,
  input  rdmt_pkg::coord_t            px,
  input  rdmt_pkg::coord_t            py,
  input  rdmt_pkg::coord_t            pz,
  input  logic [3*rdmt_pkg::ROW_W-1:0] rows,
  input  rdmt_pkg::coord_t            ofs_x,
  input  rdmt_pkg::coord_t            ofs_y,
  input  rdmt_pkg::coord_t            ofs_z,
  output rdmt_pkg::coord_t            b [3]
);
  import rdmt_pkg::*;

  logic signed [MPROD_W-1:0] mprod [3][3];
  coord_t p [3];
  coord_t ofs [3];

  assign p[0] = px;
  assign p[1] = py;
  assign p[2] = pz;
  assign ofs[0] = ofs_x;
  assign ofs[1] = ofs_y;
  assign ofs[2] = ofs_z;

  // stage 1: nine coefficient products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          mprod[i][j] <= MPROD_W'($signed(rows[i*ROW_W + j*STRIDE +: COEF_W]))
                         * MPROD_W'(p[j]);
    end
  end

  // stage 2: row sums, rounding, offset, saturation
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < 3; i++) begin
        b[i] <= sat_coord(SATIN_W'($signed(
                  (MSUM_W'(mprod[i][0]) + MSUM_W'(mprod[i][1]) + MSUM_W'(mprod[i][2])
                   + MSUM_W'(1 << (CFRAC-1))) >>> CFRAC))
                  + SATIN_W'(ofs[i]));
      end
    end
  end

endmodule

/* src/rdmt_quat.sv */
module rdmt_quat (
  input  logic                clk,
  input  rdmt_pkg::stage_en_t en,
  input  rdmt_pkg::coef_t     qw,
  input  rdmt_pkg::coef_t     qx,
  input  rdmt_pkg::coef_t     qy,
  input  rdmt_pkg::coef_t     qz,
  output rdmt_pkg::rcoef_t    r [3][3]
);
  import rdmt_pkg::*;

  logic signed [QPROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  rcoef_t one;

  assign one = RCOEF_W'(1) <<< RSHIFT;

  // stage 1: quaternion products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      xx <= QPROD_W'(qx) * QPROD_W'(qx);
      yy <= QPROD_W'(qy) * QPROD_W'(qy);
      zz <= QPROD_W'(qz) * QPROD_W'(qz);
      xy <= QPROD_W'(qx) * QPROD_W'(qy);
      xz <= QPROD_W'(qx) * QPROD_W'(qz);
      yz <= QPROD_W'(qy) * QPROD_W'(qz);
      wx <= QPROD_W'(qw) * QPROD_W'(qx);
      wy <= QPROD_W'(qw) * QPROD_W'(qy);
      wz <= QPROD_W'(qw) * QPROD_W'(qz);
    end
  end

  // stage 2: unnormalized rotation matrix, scaled by 2^RSHIFT
  always_ff @(posedge clk) begin
    if (en.s2) begin
      r[0][0] <= one - (RCOEF_W'(yy) + RCOEF_W'(zz));
      r[0][1] <= RCOEF_W'(xy) - RCOEF_W'(wz);
      r[0][2] <= RCOEF_W'(xz) + RCOEF_W'(wy);
      r[1][0] <= RCOEF_W'(xy) + RCOEF_W'(wz);
      r[1][1] <= one - (RCOEF_W'(xx) + RCOEF_W'(zz));
      r[1][2] <= RCOEF_W'(yz) - RCOEF_W'(wx);
      r[2][0] <= RCOEF_W'(xz) - RCOEF_W'(wy);
      r[2][1] <= RCOEF_W'(yz) + RCOEF_W'(wx);
      r[2][2] <= one - (RCOEF_W'(xx) + RCOEF_W'(yy));
    end
  end

endmodule

/* src/rdmt_rotate.sv */
module rdmt_rotate (
  input  logic                clk,
  input  rdmt_pkg::stage_en_t en,
  input  rdmt_pkg::coord_t    b [3],
  input  rdmt_pkg::rcoef_t    r [3][3],
  input  rdmt_pkg::coord_t    pos [3],
  output rdmt_pkg::coord_t    map [3]
);
  import rdmt_pkg::*;

  logic signed [RPROD_W-1:0] rprod [3][3];
  logic signed [RSUM_W-1:0]  rsum [3];

  // stage 3: matrix-vector products
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          rprod[i][j] <= RPROD_W'(r[i][j]) * RPROD_W'(b[j]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      rsum[i] = RSUM_W'(rprod[i][0]) + RSUM_W'(rprod[i][1]) + RSUM_W'(rprod[i][2])
                + (RSUM_W'(1) <<< (RSHIFT-1));
  end

  // stage 4: round, translate, saturate
  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int i = 0; i < 3; i++)
        map[i] <= sat_coord(SATIN_W'($signed(rsum[i][RSUM_W-1:RSHIFT])) + SATIN_W'(pos[i]));
    end
  end

endmodule

/* src/radar_detection_to_map_transform.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | command, point_*, quat_*, speed_*
// out     | output    | out_valid / out_ready| map_*, ground_speed_*
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle unless the output stalls; a detection is valid on the output after
// it has passed the four register stages (products, row sums, rotation products,
// round and translate; the first one loads at accept).
// Pose and velocity updates take effect at accept and give no result.
// Reset restores identity mount, zero offsets, zero pose and velocity.
// Each stage holds only while its successor is full and stalled.
module radar_detection_to_map_transform (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  rdmt_pkg::coord_t         point_x,
  input  rdmt_pkg::coord_t         point_y,
  input  rdmt_pkg::coord_t         point_z,
  input  rdmt_pkg::coef_t          quat_w,
  input  rdmt_pkg::coef_t          quat_x,
  input  rdmt_pkg::coef_t          quat_y,
  input  rdmt_pkg::coef_t          quat_z,
  input  rdmt_pkg::speed_t         speed_x,
  input  rdmt_pkg::speed_t         speed_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rdmt_pkg::coord_t         map_x,
  output rdmt_pkg::coord_t         map_y,
  output rdmt_pkg::coord_t         map_z,
  output rdmt_pkg::speed_t         ground_speed_x,
  output rdmt_pkg::speed_t         ground_speed_y,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [rdmt_pkg::ROW_W-1:0] cfg_data
);
  import rdmt_pkg::*;

  // configuration
  logic [3*ROW_W-1:0] rows;
  coord_t ofs_x, ofs_y, ofs_z;

  // vehicle state
  coord_t veh_pos [3];
  coef_t  qw, qx, qy, qz;
  speed_t ego_x, ego_y;

  // pipeline control
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc, det_acc;
  stage_en_t en;

  // carried payload
  coord_t pos1 [3];
  coord_t pos2 [3];
  coord_t pos3 [3];
  speed_t gs1x, gs1y, gs2x, gs2y, gs3x, gs3y;

  coord_t b [3];
  rcoef_t r [3][3];
  coord_t map [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows  <= {ROW_W'(1) << (CFRAC + 2*STRIDE), ROW_W'(1) << (CFRAC + STRIDE),
                ROW_W'(1) << CFRAC};
      ofs_x <= '0;
      ofs_y <= '0;
      ofs_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW0: rows[0*ROW_W +: ROW_W] <= cfg_data;
        REG_ROW1: rows[1*ROW_W +: ROW_W] <= cfg_data;
        REG_ROW2: rows[2*ROW_W +: ROW_W] <= cfg_data;
        REG_OFSX: ofs_x <= cfg_data[COORD_W-1:0];
        REG_OFSY: ofs_y <= cfg_data[COORD_W-1:0];
        REG_OFSZ: ofs_z <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: each stage takes data when empty or when its successor moves
  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign in_acc  = in_valid && in_ready;
  assign det_acc = in_acc && (command == CMD_DET);

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= det_acc;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // state updates at accept; detections snapshot state as they enter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) veh_pos[i] <= '0;
      qw <= '0;
      qx <= '0;
      qy <= '0;
      qz <= '0;
      ego_x <= '0;
      ego_y <= '0;
    end else if (in_acc) begin
      case (command)
        CMD_POSE: begin
          veh_pos[0] <= point_x;
          veh_pos[1] <= point_y;
          veh_pos[2] <= point_z;
          qw <= quat_w;
          qx <= quat_x;
          qy <= quat_y;
          qz <= quat_z;
        end
        CMD_VEL: begin
          ego_x <= speed_x;
          ego_y <= speed_y;
        end
        default: ;
      endcase
    end
  end

  // carried position and ground speed
  always_ff @(posedge clk) begin
    if (en.s1) begin
      pos1 <= veh_pos;
      gs1x <= sat_speed((SPEED_W+1)'(speed_x) + (SPEED_W+1)'(ego_x));
      gs1y <= sat_speed((SPEED_W+1)'(speed_y) + (SPEED_W+1)'(ego_y));
    end
    if (en.s2) begin
      pos2 <= pos1;
      gs2x <= gs1x;
      gs2y <= gs1y;
    end
    if (en.s3) begin
      pos3 <= pos2;
      gs3x <= gs2x;
      gs3y <= gs2y;
    end
    if (en.s4) begin
      ground_speed_x <= gs3x;
      ground_speed_y <= gs3y;
    end
  end

  rdmt_mount u_mount (
    .clk   (clk),
    .en    (en),
    .px    (point_x),
    .py    (point_y),
    .pz    (point_z),
    .rows  (rows),
    .ofs_x (ofs_x),
    .ofs_y (ofs_y),
    .ofs_z (ofs_z),
    .b     (b)
  );

  rdmt_quat u_quat (
    .clk (clk),
    .en  (en),
    .qw  (qw),
    .qx  (qx),
    .qy  (qy),
    .qz  (qz),
    .r   (r)
  );

  rdmt_rotate u_rotate (
    .clk (clk),
    .en  (en),
    .b   (b),
    .r   (r),
    .pos (pos3),
    .map (map)
  );

  assign out_valid = v4;
  assign map_x = map[0];
  assign map_y = map[1];
  assign map_z = map[2];

  // updates and unused commands never start a pipeline item
  a_no_update_item: assert property (@(posedge clk) disable iff (rst)
    in_acc && (command != CMD_DET) |=> !v1)
    else $error("update command entered pipeline");

  // an accepted detection always occupies stage 1 next cycle
  a_det_enters: assert property (@(posedge clk) disable iff (rst)
    det_acc |=> v1)
    else $error("detection lost at entry");

  // input back-pressure only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && v4 && !out_ready))
    else $error("stall with pipeline bubble");

endmodule

/* tb/rdmt_map_checker.sv */
`timescale 1ns / 100ps

module rdmt_map_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                command,
  input  rdmt_pkg::coord_t          point_x,
  input  rdmt_pkg::coord_t          point_y,
  input  rdmt_pkg::coord_t          point_z,
  input  rdmt_pkg::coef_t           quat_w,
  input  rdmt_pkg::coef_t           quat_x,
  input  rdmt_pkg::coef_t           quat_y,
  input  rdmt_pkg::coef_t           quat_z,
  input  rdmt_pkg::speed_t          speed_x,
  input  rdmt_pkg::speed_t          speed_y,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  rdmt_pkg::coord_t          map_x,
  input  rdmt_pkg::coord_t          map_y,
  input  rdmt_pkg::coord_t          map_z,
  input  rdmt_pkg::speed_t          ground_speed_x,
  input  rdmt_pkg::speed_t          ground_speed_y,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [rdmt_pkg::ROW_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import rdmt_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t mx;
    coord_t my;
    coord_t mz;
    speed_t gx;
    speed_t gy;
  } map_point_t;

  logic [ROW_W-1:0] mount_rows [3];
  coord_t           mount_ofs  [3];
  coord_t           veh_pos    [3];
  coef_t            veh_quat   [4];
  speed_t           ego_vel    [2];
  map_point_t       expected_points [$];

  function automatic wide_t clamp(input wide_t v, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic map_point_t transform_detection(input coord_t px, input coord_t py,
                                                      input coord_t pz, input speed_t sx,
                                                      input speed_t sy);
    wide_t      p [3];
    wide_t      b [3];
    wide_t      r [3][3];
    wide_t      m [3];
    wide_t      acc;
    wide_t      c;
    wide_t      qw, qx, qy, qz, one;
    map_point_t res;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        c = coef_t'(mount_rows[i][STRIDE*j +: COEF_W]);
        acc += c * p[j];
      end
      acc = (acc + (wide_t'(1) <<< (CFRAC - 1))) >>> CFRAC;
      b[i] = clamp(acc + wide_t'(mount_ofs[i]), COORD_W);
    end
    qw = veh_quat[0]; qx = veh_quat[1]; qy = veh_quat[2]; qz = veh_quat[3];
    one = wide_t'(1) <<< RSHIFT;
    r[0][0] = one - (qy*qy + qz*qz);
    r[0][1] = qx*qy - qw*qz;
    r[0][2] = qx*qz + qw*qy;
    r[1][0] = qx*qy + qw*qz;
    r[1][1] = one - (qx*qx + qz*qz);
    r[1][2] = qy*qz - qw*qx;
    r[2][0] = qx*qz - qw*qy;
    r[2][1] = qy*qz + qw*qx;
    r[2][2] = one - (qx*qx + qy*qy);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += r[i][j] * b[j];
      acc = (acc + (wide_t'(1) <<< (RSHIFT - 1))) >>> RSHIFT;
      m[i] = clamp(acc + wide_t'(veh_pos[i]), COORD_W);
    end
    res.mx = coord_t'(m[0]);
    res.my = coord_t'(m[1]);
    res.mz = coord_t'(m[2]);
    res.gx = speed_t'(clamp(wide_t'(sx) + wide_t'(ego_vel[0]), SPEED_W));
    res.gy = speed_t'(clamp(wide_t'(sy) + wide_t'(ego_vel[1]), SPEED_W));
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    map_point_t want;
    map_point_t got;
    if (rst) begin
      mount_rows[0] = ROW_W'(1) << CFRAC;
      mount_rows[1] = (ROW_W'(1) << CFRAC) << STRIDE;
      mount_rows[2] = (ROW_W'(1) << CFRAC) << (2 * STRIDE);
      for (int i = 0; i < 3; i++) begin
        mount_ofs[i] = '0;
        veh_pos[i]   = '0;
      end
      for (int i = 0; i < 4; i++) veh_quat[i] = '0;
      ego_vel[0] = '0;
      ego_vel[1] = '0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW0: mount_rows[0] = cfg_data;
          REG_ROW1: mount_rows[1] = cfg_data;
          REG_ROW2: mount_rows[2] = cfg_data;
          REG_OFSX: mount_ofs[0]  = coord_t'(cfg_data[COORD_W-1:0]);
          REG_OFSY: mount_ofs[1]  = coord_t'(cfg_data[COORD_W-1:0]);
          REG_OFSZ: mount_ofs[2]  = coord_t'(cfg_data[COORD_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (command)
          CMD_DET: expected_points.insert(expected_points.size(),
                     transform_detection(point_x, point_y, point_z, speed_x, speed_y));
          CMD_POSE: begin
            veh_pos[0] = point_x; veh_pos[1] = point_y; veh_pos[2] = point_z;
            veh_quat[0] = quat_w; veh_quat[1] = quat_x;
            veh_quat[2] = quat_y; veh_quat[3] = quat_z;
          end
          CMD_VEL: begin
            ego_vel[0] = speed_x;
            ego_vel[1] = speed_y;
          end
          default: ;  // unused command, no effect
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{map_x, map_y, map_z, ground_speed_x, ground_speed_y};
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected map point %h", got);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"map point mismatch: exp x=%0d y=%0d z=%0d vx=%0d vy=%0d,",
                        " got x=%0d y=%0d z=%0d vx=%0d vy=%0d"},
                       want.mx, want.my, want.mz, want.gx, want.gy,
                       got.mx, got.my, got.mz, got.gx, got.gy);
          end
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

/* tb/tb_radar_detection_to_map_transform.sv */
`timescale 1ns / 100ps

module tb_radar_detection_to_map_transform;
  import rdmt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 12;   // pipeline is four deep, leave margin
  localparam logic [1:0] CMD_SPARE = 2'd3;   // unused command code

  typedef struct {
    logic [1:0] cmd;
    coord_t     px, py, pz;
    coef_t      qw, qx, qy, qz;
    speed_t     sx, sy;
  } radar_item_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       command;
  coord_t           point_x, point_y, point_z;
  coef_t            quat_w, quat_x, quat_y, quat_z;
  speed_t           speed_x, speed_y;
  logic             out_valid;
  logic             out_ready;
  coord_t           map_x, map_y, map_z;
  speed_t           ground_speed_x, ground_speed_y;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [2:0]       cfg_index;
  logic [ROW_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycles;
  int idle_pct;      // sender idle chance, percent
  int stall_pct;     // receiver stall chance, percent
  int hold_cycles;   // long receiver hold-off, counted down by the receiver

  radar_detection_to_map_transform i_dut (.*);

  rdmt_map_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("radar_detection_to_map_transform verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus an occasional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one item; returns at the falling edge after acceptance
  task automatic offer(input radar_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command = it.cmd;
    point_x = it.px; point_y = it.py; point_z = it.pz;
    quat_w = it.qw; quat_x = it.qx; quat_y = it.qy; quat_z = it.qz;
    speed_x = it.sx; speed_y = it.sy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [ROW_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until every expected map point came out and the pipe has emptied
  task automatic drain();
    in_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_mount(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                            input logic [ROW_W-1:0] r2, input coord_t ox,
                            input coord_t oy, input coord_t oz);
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
    write_reg(REG_OFSX, ROW_W'(unsigned'(ox)));
    write_reg(REG_OFSY, ROW_W'(unsigned'(oy)));
    write_reg(REG_OFSZ, ROW_W'(unsigned'(oz)));
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 1 << 24)) - coord_t'(1 << 23);
      2: return coord_t'($urandom_range(0, 1 << 16)) - coord_t'(1 << 15);
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  function automatic coef_t rand_quat_part(input bit lead);
    case ($urandom_range(2))
      0: return coef_t'($urandom);
      default: return lead ? coef_t'(16'sd16384 - $urandom_range(0, 3000))
                           : coef_t'($urandom_range(0, 8000)) - coef_t'(4000);
    endcase
  endfunction

  function automatic speed_t rand_speed();
    if ($urandom_range(1)) return speed_t'($urandom);
    return speed_t'($urandom_range(0, 4000)) - speed_t'(2000);
  endfunction

  function automatic radar_item_t rand_item();
    radar_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) it.cmd = CMD_DET;
    else if (pick < 85) it.cmd = CMD_POSE;
    else if (pick < 96) it.cmd = CMD_VEL;
    else it.cmd = CMD_SPARE;
    it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
    it.qw = rand_quat_part(1'b1);
    it.qx = rand_quat_part(1'b0);
    it.qy = rand_quat_part(1'b0);
    it.qz = rand_quat_part(1'b0);
    it.sx = rand_speed(); it.sy = rand_speed();
    return it;
  endfunction

  function automatic radar_item_t mk(input logic [1:0] c, input coord_t x, input coord_t y,
                                     input coord_t z, input coef_t w, input coef_t qx,
                                     input coef_t qy, input coef_t qz, input speed_t vx,
                                     input speed_t vy);
    radar_item_t it;
    it = '{c, x, y, z, w, qx, qy, qz, vx, vy};
    return it;
  endfunction

  function automatic logic [ROW_W-1:0] row3(input coef_t c0, input coef_t c1,
                                            input coef_t c2);
    return {c2, c1, c0};
  endfunction

  task automatic random_items(input int n, input bit pause_mid, input bit hold_mid);
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) drain();   // sender waits for all results
      if (hold_mid && k == n / 3) begin
        in_valid = 1'b0;
        @(posedge clk);
        hold_cycles = 300;   // long receiver hold-off; sender keeps offering
        @(negedge clk);
      end
      offer(rand_item());
    end
  endtask

  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;
  localparam coef_t  QMAX = 16'sh7fff;
  localparam coef_t  QMIN = 16'sh8000;
  localparam speed_t VMAX = 16'sh7fff;
  localparam speed_t VMIN = 16'sh8000;

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_DET;
    point_x = '0; point_y = '0; point_z = '0;
    quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
    speed_x = '0; speed_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROW0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset mount, zero quaternion means identity
    offer(mk(CMD_DET, 32'sd1000, -32'sd2000, 32'sd3000, 0, 0, 0, 0, 16'sd5, -16'sd5));
    offer(mk(CMD_DET, CMAX, CMIN, CMAX, 0, 0, 0, 0, VMAX, VMIN));
    offer(mk(CMD_VEL, 0, 0, 0, 0, 0, 0, 0, VMAX, VMIN));
    offer(mk(CMD_DET, 32'sd5, 32'sd6, 32'sd7, 0, 0, 0, 0, 16'sd100, -16'sd100)); // speed sat
    offer(mk(CMD_DET, 32'sd5, 32'sd6, 32'sd7, 0, 0, 0, 0, VMIN, VMAX));
    offer(mk(CMD_VEL, CMAX, CMIN, CMAX, QMIN, QMAX, QMIN, QMAX, -16'sd300, 16'sd77));
    // unit quaternion, 90 degree yaw
    offer(mk(CMD_POSE, 32'sd10000, -32'sd10000, 32'sd50, 16'sd11585, 0, 0, 16'sd11585,
             VMAX, VMAX));
    offer(mk(CMD_DET, 32'sd4096, 32'sd1024, -32'sd512, 0, 0, 0, 0, 16'sd1, 16'sd2));
    // unnormalized quaternions, used as given
    offer(mk(CMD_POSE, 0, 0, 0, QMAX, QMAX, QMAX, QMAX, 0, 0));
    offer(mk(CMD_DET, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0));
    offer(mk(CMD_DET, CMIN, CMIN, CMIN, 0, 0, 0, 0, 0, 0));
    offer(mk(CMD_POSE, CMAX, CMIN, CMAX, QMIN, QMIN, QMIN, QMIN, 0, 0));
    offer(mk(CMD_DET, 32'sd123456, -32'sd654321, 32'sd777, 0, 0, 0, 0, 0, 0));
    offer(mk(CMD_POSE, CMIN, CMAX, CMIN, QMIN, QMAX, 16'sd0, QMIN, 0, 0));
    offer(mk(CMD_DET, CMIN, CMAX, 32'sd1, 0, 0, 0, 0, 0, 0));
    // unused command must leave state alone
    offer(mk(CMD_SPARE, CMAX, CMAX, CMAX, QMAX, QMAX, QMAX, QMAX, VMAX, VMAX));
    offer(mk(CMD_DET, 32'sd99, 32'sd98, 32'sd97, 0, 0, 0, 0, 0, 0));
    // zero quaternion pose restores identity
    offer(mk(CMD_POSE, 32'sd1, 32'sd2, 32'sd3, 0, 0, 0, 0, 0, 0));
    offer(mk(CMD_DET, -32'sd1, -32'sd1, -32'sd1, 0, 0, 0, 0, -16'sd1, -16'sd1));

    // phase: reset mount, no idling
    random_items(100, 1'b0, 1'b0);
    drain();

    // phase: random mount, sender idle
    load_mount(ROW_W'({$urandom, $urandom}), ROW_W'({$urandom, $urandom}),
               ROW_W'({$urandom, $urandom}), rand_coord(), rand_coord(), rand_coord());
    idle_pct = 68; stall_pct = 0;
    random_items(120, 1'b1, 1'b0);
    drain();

    // phase: largest coefficients and offsets, receiver stalls
    load_mount(row3(QMAX, QMAX, QMAX), row3(QMAX, QMAX, QMAX), row3(QMAX, QMAX, QMAX),
               CMAX, CMAX, CMAX);
    idle_pct = 0; stall_pct = 68;
    random_items(120, 1'b0, 1'b0);
    drain();

    // phase: smallest coefficients and offsets, both sides idle
    load_mount(row3(QMIN, QMIN, QMIN), row3(QMIN, QMIN, QMIN), row3(QMIN, QMIN, QMIN),
               CMIN, CMIN, CMIN);
    idle_pct = 38; stall_pct = 38;
    random_items(120, 1'b0, 1'b0);
    drain();

    // phase: realistic mount (axes swapped, small offsets), long hold-off
    load_mount(row3(0, -16'sd16384, 0), row3(16'sd16384, 0, 0), row3(0, 0, 16'sd16384),
               32'sd1500, -32'sd300, 32'sd800);
    idle_pct = 0; stall_pct = 0;
    random_items(140, 1'b0, 1'b1);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("radar_detection_to_map_transform verification clean");
    end else begin
      $display("radar_detection_to_map_transform verification failed");
    end
    $finish;
  end

endmodule
